// ===== sv/dfs_code_builder_macros.svh =====
// ----------------------------------------------------------------------------
// dfs_code_builder_macros: assertion shorthands
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DFS_CODE_BUILDER_MACROS_SVH
`define DFS_CODE_BUILDER_MACROS_SVH

// consequent checked in the same cycle
`define DCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define DCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcb_pkg: shared types and constants of the DFS code builder
// Store sizes, derived widths, command and status codes, queue word.
// ----------------------------------------------------------------------------
package dcb_pkg;

  localparam int MAX_EDGES    = 32;
  localparam int MAX_VERTICES = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int CMDQ_DEPTH   = 2;

  localparam int EIDX_W   = $clog2(MAX_EDGES);
  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int SCAN_W   = (ECNT_W > VCNT_W) ? ECNT_W : VCNT_W;
  localparam int IDX_W    = (EIDX_W > VIDX_W) ? EIDX_W : VIDX_W;
  localparam int K_W      = $clog2(RESULT_LIMIT + 1);
  localparam int CQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int ETOT_W   = 6;

  typedef logic [1:0]        cmd_code_t;
  typedef logic [15:0]       vid_t;
  typedef logic [7:0]        label_t;
  typedef logic [2:0]        status_t;
  typedef logic [ETOT_W-1:0] etot_t;

  localparam cmd_code_t CMD_ADD    = 2'd0;
  localparam cmd_code_t CMD_REMOVE = 2'd1;
  localparam cmd_code_t CMD_QUERY  = 2'd2;
  localparam cmd_code_t CMD_CLEAR  = 2'd3;

  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_UNREACHED = 3'd1;
  localparam status_t ST_DUPLICATE = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_PATH      = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;

  typedef enum logic [1:0] {OP_ADD, OP_REMOVE, OP_QUERY, OP_CLEAR} op_t;

  typedef struct packed {
    op_t    op;
    vid_t   src_vid;
    label_t src_lbl;
    vid_t   tgt_vid;
    label_t tgt_lbl;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmdq_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0] src_idx;
    label_t            src_lbl;
    logic [VIDX_W-1:0] tgt_idx;
    label_t            tgt_lbl;
    logic              fwd;
  } edge_t;

endpackage

// ===== sv/dcb_front.sv =====
// ----------------------------------------------------------------------------
// dcb_front: command intake
// Accepts input words, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
module dcb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dcb_pkg::cmd_code_t     in_command,
  input  dcb_pkg::vid_t          in_source_vertex,
  input  dcb_pkg::label_t        in_source_label,
  input  dcb_pkg::vid_t          in_target_vertex,
  input  dcb_pkg::label_t        in_target_label,
  output dcb_pkg::cmdq_word_t    q_head,
  input  logic                   q_pop
);
  import dcb_pkg::*;

  cmd_t                q_mem [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                push;
  op_t                 op_dec;
  cmd_t                word_in;

  always_comb begin
    case (in_command)
      CMD_ADD:    op_dec = OP_ADD;
      CMD_REMOVE: op_dec = OP_REMOVE;
      CMD_QUERY:  op_dec = OP_QUERY;
      CMD_CLEAR:  op_dec = OP_CLEAR;
      default:    op_dec = OP_CLEAR;
    endcase
  end

  assign word_in = '{op: op_dec, src_vid: in_source_vertex, src_lbl: in_source_label,
                     tgt_vid: in_target_vertex, tgt_lbl: in_target_label};

  assign in_stall = (cnt_r == CQ_CNT_W'(CMDQ_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_PTR_W'(1);
    end
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + CQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= word_in;
    end
  end

  assign q_head.vld = (cnt_r != '0);
  assign q_head.cmd = q_mem[rd_ptr_r];

endmodule

// ===== sv/dcb_back.sv =====
// ----------------------------------------------------------------------------
// dcb_back: DFS code engine
// Sequencer over the edge store and vertex map; scans one entry per cycle
// and drives the registered result port.
// ----------------------------------------------------------------------------
module dcb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dcb_pkg::cmdq_word_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dcb_pkg::status_t    out_status,
  output dcb_pkg::vid_t       out_vertex_id,
  output dcb_pkg::etot_t      out_edge_total,
  output logic                out_last
);
  import dcb_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOOK    = 4'd1;
  localparam logic [3:0] S_ADD_DEC = 4'd2;
  localparam logic [3:0] S_DUP     = 4'd3;
  localparam logic [3:0] S_ADD_CAP = 4'd4;
  localparam logic [3:0] S_ADD_T   = 4'd5;
  localparam logic [3:0] S_ADD_E   = 4'd6;
  localparam logic [3:0] S_RM_RD   = 4'd7;
  localparam logic [3:0] S_RM      = 4'd8;
  localparam logic [3:0] S_QF      = 4'd9;
  localparam logic [3:0] S_MAP     = 4'd10;
  localparam logic [3:0] S_PUT     = 4'd11;
  localparam logic [3:0] S_WALK    = 4'd12;
  localparam logic [3:0] S_FLUSH   = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  // stores
  edge_t edge_mem [MAX_EDGES];
  vid_t  vmap     [MAX_VERTICES];
  edge_t edge_rdata_r;
  vid_t  vm_rdata_r;

  logic              edge_we;
  logic [EIDX_W-1:0] edge_waddr, edge_raddr;
  edge_t             edge_wdata;
  logic              vm_we;
  logic [VIDX_W-1:0] vm_waddr, vm_raddr;
  vid_t              vm_wdata;

  // control
  logic [3:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ECNT_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [VCNT_W-1:0] vert_cnt_r, vert_cnt_nxt;
  logic [SCAN_W-1:0] scan_i_r, scan_i_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              s_known_r, s_known_nxt;
  logic              t_known_r, t_known_nxt;
  logic [VIDX_W-1:0] s_idx_r, s_idx_nxt;
  logic [VIDX_W-1:0] t_idx_r, t_idx_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [VIDX_W-1:0] cur_r, cur_nxt;
  logic [VIDX_W-1:0] q_tgt_r, q_tgt_nxt;
  logic              q_tgt_pend_r, q_tgt_pend_nxt;
  logic [VIDX_W-1:0] map_idx_r, map_idx_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              pnd_vld_r, pnd_vld_nxt;
  vid_t              pnd_id_r, pnd_id_nxt;

  // result register
  logic              out_vld_r, out_vld_nxt;
  status_t           out_status_r;
  vid_t              out_id_r;
  etot_t             out_etot_r;
  logic              out_last_r;

  logic              can_load;
  logic              load;
  status_t           ld_status;
  vid_t              ld_id;
  logic              ld_last;

  logic [SCAN_W-1:0] scan_dec;
  logic [ECNT_W-1:0] rm_addr;
  logic [1:0]        need;
  logic [VCNT_W:0]   vert_sum;

  assign can_load = !out_vld_r || !out_stall;
  assign scan_dec = scan_i_r - SCAN_W'(1);
  assign rm_addr  = edge_cnt_r - ECNT_W'(1);
  assign need     = {1'b0, !s_known_r} + {1'b0, !t_known_r};
  assign vert_sum = (VCNT_W + 1)'(vert_cnt_r) + (VCNT_W + 1)'(need);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    edge_cnt_nxt   = edge_cnt_r;
    vert_cnt_nxt   = vert_cnt_r;
    scan_i_nxt     = scan_i_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    s_known_nxt    = s_known_r;
    t_known_nxt    = t_known_r;
    s_idx_nxt      = s_idx_r;
    t_idx_nxt      = t_idx_r;
    res_status_nxt = res_status_r;
    cur_nxt        = cur_r;
    q_tgt_nxt      = q_tgt_r;
    q_tgt_pend_nxt = q_tgt_pend_r;
    map_idx_nxt    = map_idx_r;
    k_nxt          = k_r;
    pnd_vld_nxt    = pnd_vld_r;
    pnd_id_nxt     = pnd_id_r;
    q_pop          = 1'b0;
    edge_we        = 1'b0;
    edge_waddr     = edge_cnt_r[EIDX_W-1:0];
    edge_wdata     = '{src_idx: s_idx_r, src_lbl: cmd_r.src_lbl, tgt_idx: t_idx_r,
                       tgt_lbl: cmd_r.tgt_lbl, fwd: !(s_known_r && t_known_r)};
    edge_raddr     = scan_i_r[EIDX_W-1:0];
    vm_we          = 1'b0;
    vm_waddr       = vert_cnt_r[VIDX_W-1:0];
    vm_wdata       = cmd_r.src_vid;
    vm_raddr       = map_idx_r;
    load           = 1'b0;
    ld_status      = res_status_r;
    ld_id          = '0;
    ld_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (q_head.vld) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_head.cmd;
          scan_i_nxt  = '0;
          chk_vld_nxt = 1'b0;
          s_known_nxt = 1'b0;
          t_known_nxt = 1'b0;
          k_nxt       = '0;
          case (q_head.cmd.op)
            OP_ADD: begin
              state_nxt = S_LOOK;
            end
            OP_REMOVE: begin
              if (edge_cnt_r <= ECNT_W'(1)) begin
                edge_cnt_nxt   = '0;
                vert_cnt_nxt   = '0;
                res_status_nxt = ST_DONE;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            OP_QUERY: begin
              if (edge_cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                scan_i_nxt = SCAN_W'(edge_cnt_r);
                state_nxt  = S_QF;
              end
            end
            default: begin
              edge_cnt_nxt   = '0;
              vert_cnt_nxt   = '0;
              res_status_nxt = ST_DONE;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      // both ids looked up in one pass, first match wins
      S_LOOK: begin
        if (chk_vld_r) begin
          if (!s_known_r && vm_rdata_r == cmd_r.src_vid) begin
            s_known_nxt = 1'b1;
            s_idx_nxt   = chk_idx_r[VIDX_W-1:0];
          end
          if (!t_known_r && vm_rdata_r == cmd_r.tgt_vid) begin
            t_known_nxt = 1'b1;
            t_idx_nxt   = chk_idx_r[VIDX_W-1:0];
          end
        end
        if (scan_i_r < SCAN_W'(vert_cnt_r)) begin
          vm_raddr    = scan_i_r[VIDX_W-1:0];
          scan_i_nxt  = scan_i_r + SCAN_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_i_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = S_ADD_DEC;
          end
        end
      end

      S_ADD_DEC: begin
        if (!s_known_r && t_known_r) begin
          res_status_nxt = ST_UNREACHED;
          state_nxt      = S_EMIT;
        end else if (s_known_r && t_known_r) begin
          scan_i_nxt  = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_DUP;
        end else begin
          state_nxt = S_ADD_CAP;
        end
      end

      S_DUP: begin
        if (chk_vld_r &&
            ((edge_rdata_r.src_idx == s_idx_r && edge_rdata_r.tgt_idx == t_idx_r) ||
             (edge_rdata_r.src_idx == t_idx_r && edge_rdata_r.tgt_idx == s_idx_r))) begin
          chk_vld_nxt    = 1'b0;
          res_status_nxt = ST_DUPLICATE;
          state_nxt      = S_EMIT;
        end else if (scan_i_r < SCAN_W'(edge_cnt_r)) begin
          edge_raddr  = scan_i_r[EIDX_W-1:0];
          scan_i_nxt  = scan_i_r + SCAN_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_i_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = S_ADD_CAP;
          end
        end
      end

      S_ADD_CAP: begin
        if (edge_cnt_r >= ECNT_W'(MAX_EDGES) ||
            vert_sum > (VCNT_W + 1)'(MAX_VERTICES)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          if (!s_known_r) begin
            vm_we        = 1'b1;
            vm_wdata     = cmd_r.src_vid;
            s_idx_nxt    = vert_cnt_r[VIDX_W-1:0];
            vert_cnt_nxt = vert_cnt_r + VCNT_W'(1);
          end
          state_nxt = S_ADD_T;
        end
      end

      S_ADD_T: begin
        if (!t_known_r) begin
          vm_we        = 1'b1;
          vm_wdata     = cmd_r.tgt_vid;
          t_idx_nxt    = vert_cnt_r[VIDX_W-1:0];
          vert_cnt_nxt = vert_cnt_r + VCNT_W'(1);
        end
        state_nxt = S_ADD_E;
      end

      S_ADD_E: begin
        edge_we        = 1'b1;
        edge_cnt_nxt   = edge_cnt_r + ECNT_W'(1);
        res_status_nxt = ST_DONE;
        state_nxt      = S_EMIT;
      end

      S_RM_RD: begin
        edge_raddr = rm_addr[EIDX_W-1:0];
        state_nxt  = S_RM;
      end

      // a forward edge drops only the newest map entry
      S_RM: begin
        if (edge_rdata_r.fwd && vert_cnt_r != '0) begin
          vert_cnt_nxt = vert_cnt_r - VCNT_W'(1);
        end
        edge_cnt_nxt   = rm_addr;
        res_status_nxt = ST_DONE;
        state_nxt      = S_EMIT;
      end

      // backward scan for the last forward edge
      S_QF: begin
        if (chk_vld_r && edge_rdata_r.fwd) begin
          cur_nxt        = edge_rdata_r.src_idx;
          map_idx_nxt    = edge_rdata_r.src_idx;
          q_tgt_nxt      = edge_rdata_r.tgt_idx;
          q_tgt_pend_nxt = 1'b1;
          scan_i_nxt     = SCAN_W'(chk_idx_r) + SCAN_W'(1);
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_MAP;
        end else if (scan_i_r != '0) begin
          edge_raddr  = scan_dec[EIDX_W-1:0];
          scan_i_nxt  = scan_dec;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_dec[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_EMIT;
          end
        end
      end

      S_MAP: begin
        state_nxt = S_PUT;
      end

      // one path word is held back so the final one can carry last
      S_PUT: begin
        if (!pnd_vld_r || can_load) begin
          if (pnd_vld_r) begin
            load      = 1'b1;
            ld_status = ST_PATH;
            ld_id     = pnd_id_r;
            ld_last   = 1'b0;
          end
          pnd_id_nxt  = vm_rdata_r;
          pnd_vld_nxt = 1'b1;
          k_nxt       = k_r + K_W'(1);
          if (q_tgt_pend_r) begin
            q_tgt_pend_nxt = 1'b0;
            map_idx_nxt    = q_tgt_r;
            state_nxt      = S_MAP;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (k_r >= K_W'(RESULT_LIMIT)) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_FLUSH;
        end else if (chk_vld_r && edge_rdata_r.fwd && edge_rdata_r.tgt_idx == cur_r) begin
          cur_nxt     = edge_rdata_r.src_idx;
          map_idx_nxt = edge_rdata_r.src_idx;
          scan_i_nxt  = SCAN_W'(chk_idx_r);
          chk_vld_nxt = 1'b0;
          state_nxt   = S_MAP;
        end else if (scan_i_r != '0) begin
          edge_raddr  = scan_dec[EIDX_W-1:0];
          scan_i_nxt  = scan_dec;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_dec[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (can_load) begin
          load        = 1'b1;
          ld_status   = ST_PATH;
          ld_id       = pnd_id_r;
          ld_last     = 1'b1;
          pnd_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      S_EMIT: begin
        if (can_load) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = load ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      edge_cnt_r <= '0;
      vert_cnt_r <= '0;
      chk_vld_r  <= 1'b0;
      pnd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      vert_cnt_r <= vert_cnt_nxt;
      chk_vld_r  <= chk_vld_nxt;
      pnd_vld_r  <= pnd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_i_r     <= scan_i_nxt;
    chk_idx_r    <= chk_idx_nxt;
    s_known_r    <= s_known_nxt;
    t_known_r    <= t_known_nxt;
    s_idx_r      <= s_idx_nxt;
    t_idx_r      <= t_idx_nxt;
    res_status_r <= res_status_nxt;
    cur_r        <= cur_nxt;
    q_tgt_r      <= q_tgt_nxt;
    q_tgt_pend_r <= q_tgt_pend_nxt;
    map_idx_r    <= map_idx_nxt;
    k_r          <= k_nxt;
    pnd_id_r     <= pnd_id_nxt;
    if (load) begin
      out_status_r <= ld_status;
      out_id_r     <= ld_id;
      out_etot_r   <= ETOT_W'(edge_cnt_r);
      out_last_r   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmap[vm_waddr] <= vm_wdata;
    end
    vm_rdata_r <= vmap[vm_raddr];
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_vertex_id  = out_id_r;
  assign out_edge_total = out_etot_r;
  assign out_last       = out_last_r;

endmodule

// ===== sv/dfs_code_builder.sv =====
// ----------------------------------------------------------------------------
// dfs_code_builder: graph-mining DFS code store (V map, E edge entries in use)
// Add scans the map, and edges if both ends are known; scans read one entry a cycle.
// Query scans edges backward, reads the map per path word. One command at a time.
// Sync active-low reset empties the 2-word queue and both counts; RAMs keep old data.
// ----------------------------------------------------------------------------
module dfs_code_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcb_pkg::cmd_code_t in_command,
  input  dcb_pkg::vid_t      in_source_vertex,
  input  dcb_pkg::label_t    in_source_label,
  input  dcb_pkg::vid_t      in_target_vertex,
  input  dcb_pkg::label_t    in_target_label,
  output logic               out_valid,
  input  logic               out_stall,
  output dcb_pkg::status_t   out_status,
  output dcb_pkg::vid_t      out_vertex_id,
  output dcb_pkg::etot_t     out_edge_total,
  output logic               out_last
);
  import dcb_pkg::*;

  `include "dfs_code_builder_macros.svh"

  cmdq_word_t q_head;
  logic       q_pop;

  dcb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_source_vertex (in_source_vertex),
    .in_source_label  (in_source_label),
    .in_target_vertex (in_target_vertex),
    .in_target_label  (in_target_label),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  dcb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_vertex_id  (out_vertex_id),
    .out_edge_total (out_edge_total),
    .out_last       (out_last)
  );

  `DCB_ASSERT_SAME(a_pop_needs_word, q_pop, q_head.vld, "pop from empty command queue")
  `DCB_ASSERT_NEXT(a_accept_queued, in_valid && !in_stall, q_head.vld, "accepted word lost")
  `DCB_ASSERT_SAME(a_single_word, out_valid && (out_status != ST_PATH),
                   out_last && (out_vertex_id == '0), "bad non-path word")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the DFS code builder
// Drives add, remove, query and clear commands in bursts against a random
// output stall pattern. Accepted add, remove and clear commands update a local
// copy of the edge list and vertex map. Each output word is compared field by
// field with the oldest predicted word.
// ----------------------------------------------------------------------------
module tb;
  import dcb_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 64;
  localparam int PRINT_CAP    = 40;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    status_t status;
    vid_t    vertex_id;
    etot_t   edge_total;
    logic    last;
  } result_word_t;

  logic      clk              = 1'b0;
  logic      rst_n            = 1'b0;
  logic      in_valid         = 1'b0;
  logic      in_stall;
  cmd_code_t in_command       = CMD_CLEAR;
  vid_t      in_source_vertex = '0;
  label_t    in_source_label  = '0;
  vid_t      in_target_vertex = '0;
  label_t    in_target_label  = '0;
  logic      out_valid;
  logic      out_stall        = 1'b0;
  status_t   out_status;
  vid_t      out_vertex_id;
  etot_t     out_edge_total;
  logic      out_last;

  dfs_code_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_source_vertex (in_source_vertex),
    .in_source_label  (in_source_label),
    .in_target_vertex (in_target_vertex),
    .in_target_label  (in_target_label),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_vertex_id    (out_vertex_id),
    .out_edge_total   (out_edge_total),
    .out_last         (out_last)
  );

  // local copy of the DFS code
  logic [VIDX_W-1:0] code_src_idx [MAX_EDGES];
  logic [VIDX_W-1:0] code_tgt_idx [MAX_EDGES];
  logic              code_fwd     [MAX_EDGES];
  vid_t              id_map       [MAX_VERTICES];
  int                code_edges = 0;
  int                code_verts = 0;

  result_word_t pending_results [$];

  int          fail_count   = 0;
  int          print_count  = 0;
  int unsigned cycle_count  = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_go      = 1'b0;
  int          hold_left    = 0;
  rx_mode_t    rx_mode      = RX_FREE;
  int          rx_mode_left = 0;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit find_vertex(input vid_t id, output int idx);
    idx = 0;
    for (int i = 0; i < code_verts; i++)
      if (id_map[i] == id) begin
        idx = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic void queue_result(status_t st, vid_t id, logic fin);
    result_word_t w;
    w.status     = st;
    w.vertex_id  = id;
    w.edge_total = etot_t'(code_edges);
    w.last       = fin;
    pending_results = {pending_results, w};
  endfunction

  function automatic status_t grow_code(vid_t sv, vid_t tv);
    int si, ti, need;
    bit sk, tk, fwd;
    sk  = find_vertex(sv, si);
    tk  = find_vertex(tv, ti);
    fwd = 1'b1;
    if (!sk && tk) return ST_UNREACHED;
    if (sk && tk) begin
      for (int i = 0; i < code_edges; i++)
        if ((code_src_idx[i] == si && code_tgt_idx[i] == ti) ||
            (code_src_idx[i] == ti && code_tgt_idx[i] == si))
          return ST_DUPLICATE;
      fwd = 1'b0;
    end
    need = (sk ? 0 : 1) + (tk ? 0 : 1);
    // unreached and duplicate take priority over full
    if (code_edges >= MAX_EDGES || code_verts + need > MAX_VERTICES) return ST_FULL;
    if (!sk) begin
      si = code_verts;
      id_map[code_verts] = sv;
      code_verts++;
    end
    if (!tk) begin
      ti = code_verts;
      id_map[code_verts] = tv;
      code_verts++;
    end
    code_src_idx[code_edges] = si[VIDX_W-1:0];
    code_tgt_idx[code_edges] = ti[VIDX_W-1:0];
    code_fwd[code_edges]     = fwd;
    code_edges++;
    return ST_DONE;
  endfunction

  function automatic void shrink_code();
    if (code_edges <= 1) begin
      code_edges = 0;
      code_verts = 0;
      return;
    end
    // a forward edge gives back only its newest vertex
    if (code_fwd[code_edges-1] && code_verts > 0) code_verts--;
    code_edges--;
  endfunction

  function automatic void trace_path();
    int at;
    bit found;
    logic [VIDX_W-1:0] cur;
    vid_t path_ids [$];
    at    = 0;
    found = 1'b0;
    for (int i = code_edges; i > 0; i--)
      if (code_fwd[i-1]) begin
        at    = i - 1;
        found = 1'b1;
        break;
      end
    if (!found) begin
      queue_result(ST_EMPTY, '0, 1'b1);
      return;
    end
    path_ids = {path_ids, id_map[code_src_idx[at]]};
    path_ids = {path_ids, id_map[code_tgt_idx[at]]};
    cur = code_src_idx[at];
    for (int i = at + 1; i > 0 && path_ids.size() < RESULT_LIMIT; i--)
      if (code_fwd[i-1] && code_tgt_idx[i-1] == cur) begin
        cur = code_src_idx[i-1];
        path_ids = {path_ids, id_map[cur]};
      end
    foreach (path_ids[j])
      queue_result(ST_PATH, path_ids[j], j == path_ids.size() - 1);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    if (print_count < PRINT_CAP) begin
      print_count++;
      $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    end
  endtask

  always @(posedge clk) begin : check_word
    result_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_vertex_id !== want.vertex_id)
          report_mismatch("vertex_id", out_vertex_id, want.vertex_id);
        if (out_edge_total !== want.edge_total)
          report_mismatch("edge_total", out_edge_total, want.edge_total);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // receiver: stall pattern changes at random intervals; a requested hold
  // keeps it stalled for a long stretch
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 120);
    end else begin
      rx_mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= cycle_count[2];
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  // valid stays high across a burst; it drops only for a gap
  task automatic send_word(cmd_code_t cmd, vid_t sv, label_t sl, vid_t tv, label_t tl);
    int gap;
    status_t st;
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_source_vertex <= sv;
    in_source_label  <= sl;
    in_target_vertex <= tv;
    in_target_label  <= tl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (cmd)
      CMD_ADD: begin
        st = grow_code(sv, tv);
        queue_result(st, '0, 1'b1);
      end
      CMD_REMOVE: begin
        shrink_code();
        queue_result(ST_DONE, '0, 1'b1);
      end
      CMD_QUERY: trace_path();
      default: begin
        code_edges = 0;
        code_verts = 0;
        queue_result(ST_DONE, '0, 1'b1);
      end
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic vid_t fresh_id();
    if ($urandom_range(0, 1) == 0) return vid_t'($urandom_range(0, 15));
    return vid_t'($urandom_range(0, 65535));
  endfunction

  function automatic vid_t known_id();
    return id_map[$urandom_range(0, code_verts - 1)];
  endfunction

  // mostly connected growth from known vertices, some noise
  task automatic send_random_word(int clear_pct);
    int r;
    vid_t sv, tv;
    cmd_code_t cmd;
    r  = $urandom_range(0, 99);
    sv = fresh_id();
    tv = fresh_id();
    if (r < 62) begin
      cmd = CMD_ADD;
      if (code_verts > 0 && $urandom_range(0, 9) != 0) sv = known_id();
      if (code_verts > 0 && $urandom_range(0, 1) == 0) tv = known_id();
    end else if (r < 70) begin
      cmd = CMD_ADD;
      if (code_verts > 0 && r < 66) tv = known_id();
    end else if (r < 82) begin
      cmd = CMD_REMOVE;
    end else if (r < 100 - clear_pct) begin
      cmd = CMD_QUERY;
    end else begin
      cmd = CMD_CLEAR;
    end
    send_word(cmd, sv, label_t'($urandom_range(0, 255)), tv, label_t'($urandom_range(0, 255)));
  endtask

  task automatic test_empty_store();
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
    wait_results();
  endtask

  task automatic test_edge_rules();
    send_word(CMD_ADD, 16'h0000, 8'h00, 16'hFFFF, 8'hFF);
    send_word(CMD_ADD, 16'hFFFF, 8'hFF, 16'h1234, 8'h5A);
    send_word(CMD_ADD, 16'h1234, 8'hA5, 16'h0000, 8'h00);  // backward
    send_word(CMD_ADD, 16'h0000, 8'h00, 16'h1234, 8'h01);  // reverse duplicate
    send_word(CMD_ADD, 16'hFFFF, 8'h01, 16'h1234, 8'h01);  // same-direction duplicate
    send_word(CMD_ADD, 16'h5555, 8'h33, 16'h0000, 8'h00);  // new source, known target
    send_word(CMD_ADD, 16'h7777, 8'h44, 16'h7777, 8'h44);  // equal new ids: two indices
    send_word(CMD_ADD, 16'h7777, 8'h44, 16'h0000, 8'h00);
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);  // drops one of the two new vertices
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_ADD, 16'hAAAA, 8'h10, 16'h7777, 8'h20);
    send_word(CMD_ADD, 16'h7777, 8'h20, 16'hBBBB, 8'h30);
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);
    send_word(CMD_REMOVE, '0, '0, '0, '0);  // single edge left: clears all
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_ADD, 16'h0001, 8'h02, 16'h0003, 8'h04);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
    send_word(CMD_QUERY, '0, '0, '0, '0);
    wait_results();
  endtask

  task automatic test_full_store();
    send_word(CMD_CLEAR, '0, '0, '0, '0);
    // chain uses every vertex slot; the query walks the full path
    for (int k = 0; k < MAX_VERTICES - 1; k++)
      send_word(CMD_ADD, vid_t'(16'h0100 + k), label_t'(k), vid_t'(16'h0101 + k),
                label_t'(k + 1));
    send_word(CMD_ADD, 16'h0100, 8'h11, 16'h0F00, 8'h22);
    send_word(CMD_QUERY, '0, '0, '0, '0);
    send_word(CMD_ADD, 16'h0100, 8'h11, 16'h0102, 8'h22);  // last edge slot
    send_word(CMD_ADD, 16'h0100, 8'h11, 16'h0103, 8'h22);
    send_word(CMD_ADD, 16'h0102, 8'h11, 16'h0100, 8'h22);
    send_word(CMD_ADD, 16'h0F00, 8'h11, 16'h0100, 8'h22);
    send_word(CMD_QUERY, '0, '0, '0, '0);
    wait_results();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) send_word(CMD_QUERY, '0, '0, '0, '0);
    for (int i = 0; i < 10; i++) send_random_word(0);
    gaps_on = 1'b1;
    wait_results();
  endtask

  task automatic test_random(int n_items);
    int clear_pct;
    for (int p = 0; p < 8; p++) begin
      gaps_on   = (p % 3 != 2);
      clear_pct = $urandom_range(0, 6);
      for (int i = 0; i < n_items / 8; i++) send_random_word(clear_pct);
      if (p % 2 == 1) wait_results();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_edge_rules();
    test_full_store();
    test_backpressure();
    test_random(320);
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ===== dfs_code_builder.f =====
+incdir+sv
sv/dcb_pkg.sv
sv/dcb_front.sv
sv/dcb_back.sv
sv/dfs_code_builder.sv
dv/tb.sv
